/* hw/rtl/cps_pkg.sv */
// Shared types and constants for the connection pair selector.
`default_nettype none

package cps_pkg;

  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_EVAL   = 2'd2;
  localparam logic [1:0] MODE_SELECT = 2'd3;

  localparam logic [1:0]  WS_UNRELIABLE = 2'd1;
  localparam logic [15:0] MIN_IMP_RESET = 16'd10;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  slot;
    logic        writable;
    logic [1:0]  wr_state;
    logic        receiving;
    logic [62:0] priority_req;
    logic [15:0] rtt_ms;
    logic        has_selection;
  } cps_in_t;

  typedef struct packed {
    logic       switch_found;
    logic [3:0] switch_slot;
    logic       best_valid;
    logic [3:0] best_slot;
  } cps_out_t;

  // One table entry as it is kept in the pair RAM.
  typedef struct packed {
    logic        writable;
    logic [1:0]  wr_state;
    logic        receiving;
    logic [62:0] prio;
    logic [15:0] rtt;
  } cps_entry_t;

  localparam int ENTRY_W = $bits(cps_entry_t);

  typedef struct packed {
    logic apply;      // table or selection update from the accepted word
    logic scan_init;  // clear the running best and rewind the scan index
    logic scan_rd;    // read the entry at the scan index and advance
    logic sel_rd;     // read the selected entry
    logic finish;     // form the evaluate result
  } cps_cmd_t;

  typedef struct packed {
    logic scan_last;
  } cps_status_t;

endpackage

`default_nettype wire

/* hw/rtl/cps_ram.sv */
// Generic single write port RAM with one registered read port.
`default_nettype none

module cps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/cps_ctrl.sv */
// Control state machine: sequences updates and the evaluate scan.
`default_nettype none

module cps_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [1:0]          in_mode,
  input  wire cps_pkg::cps_status_t status,
  output logic                     busy,
  output cps_pkg::cps_cmd_t        cmd
);
  import cps_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SELRD = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_mode == MODE_EVAL) begin
            cmd.scan_init = 1'b1;
            state_nxt     = ST_SCAN;
          end else begin
            cmd.apply = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.scan_last) begin
          state_nxt = ST_SELRD;
        end
      end
      ST_SELRD: begin
        cmd.sel_rd = 1'b1;
        state_nxt  = ST_FIN;
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

`default_nettype wire

/* hw/rtl/cps_dp.sv */
// Datapath: pair table, valid bits, selection, ranking comparator and result register.
`default_nettype none

module cps_dp #(
  parameter int MAX_PAIRS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cps_pkg::cps_in_t    in_word,
  input  wire cps_pkg::cps_cmd_t   cmd,
  input  wire logic                cfg_we,
  input  wire logic [15:0]         cfg_wdata,
  output cps_pkg::cps_status_t     status,
  output logic                     out_strobe,
  output cps_pkg::cps_out_t        out_word
);
  import cps_pkg::*;

  localparam int SLOT_W = $clog2(MAX_PAIRS);
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(MAX_PAIRS - 1);

  // True when entry a ranks strictly above entry b.
  function automatic logic ranks_above(input cps_entry_t a, input cps_entry_t b);
    logic r;
    if (a.writable != b.writable) begin
      r = a.writable;
    end else if (a.wr_state != b.wr_state) begin
      r = (a.wr_state < b.wr_state);
    end else if (a.receiving != b.receiving) begin
      r = a.receiving;
    end else if (a.prio != b.prio) begin
      r = (a.prio > b.prio);
    end else begin
      r = (a.rtt < b.rtt);
    end
    return r;
  endfunction

  logic [MAX_PAIRS-1:0] valid_r, valid_nxt;
  logic                 sel_valid_r, sel_valid_nxt;
  logic [SLOT_W-1:0]    sel_slot_r, sel_slot_nxt;
  logic [15:0]          min_imp_r;
  logic [SLOT_W-1:0]    idx_r, idx_nxt;
  logic                 cmp_v_r;
  logic [SLOT_W-1:0]    cmp_idx_r;
  logic                 best_found_r, best_found_nxt;
  logic [SLOT_W-1:0]    best_idx_r, best_idx_nxt;
  cps_entry_t           best_r, best_nxt;
  logic                 out_strobe_r;
  cps_out_t             out_word_r, out_word_nxt;

  logic [SLOT_W-1:0] slot_idx;
  logic              in_range;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_raddr;
  cps_entry_t        ram_wdata;
  cps_entry_t        ram_rdata;
  logic              take;
  logic              ready;
  logic [16:0]       rtt_sum;
  logic              gain_ok;
  logic              sw;

  assign slot_idx = SLOT_W'(in_word.slot);
  assign in_range = ({28'd0, in_word.slot} < 32'(MAX_PAIRS));

  assign ram_we    = cmd.apply && (in_word.mode == MODE_WRITE) && in_range;
  assign ram_wdata = '{writable:    in_word.writable,
                       wr_state:    in_word.wr_state,
                       receiving:   in_word.receiving,
                       prio:        in_word.priority_req,
                       rtt:         in_word.rtt_ms};
  assign ram_raddr = cmd.sel_rd ? sel_slot_r : idx_r;

  cps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PAIRS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_idx),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign status.scan_last = (idx_r == LAST_IDX);

  // Table and selection updates.
  always_comb begin
    valid_nxt     = valid_r;
    sel_valid_nxt = sel_valid_r;
    sel_slot_nxt  = sel_slot_r;
    if (cmd.apply) begin
      case (in_word.mode)
        MODE_WRITE: begin
          if (in_range) begin
            valid_nxt[slot_idx] = 1'b1;
          end
        end
        MODE_REMOVE: begin
          if (in_range) begin
            valid_nxt[slot_idx] = 1'b0;
            if (sel_valid_r && (sel_slot_r == slot_idx)) begin
              sel_valid_nxt = 1'b0;
            end
          end
        end
        MODE_SELECT: begin
          if (!in_word.has_selection) begin
            sel_valid_nxt = 1'b0;
          end else if (in_range && valid_r[slot_idx]) begin
            sel_valid_nxt = 1'b1;
            sel_slot_nxt  = slot_idx;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Running best: the data read last cycle is compared against it.
  assign take = cmp_v_r && valid_r[cmp_idx_r] &&
                (!best_found_r || ranks_above(ram_rdata, best_r));

  always_comb begin
    idx_nxt        = idx_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_nxt       = best_r;
    if (cmd.scan_init) begin
      idx_nxt        = '0;
      best_found_nxt = 1'b0;
    end else if (cmd.scan_rd) begin
      idx_nxt = idx_r + 1'b1;
    end
    if (take) begin
      best_found_nxt = 1'b1;
      best_idx_nxt   = cmp_idx_r;
      best_nxt       = ram_rdata;
    end
  end

  // Decision: in the finish cycle the RAM output holds the selected entry.
  assign ready   = best_r.writable || (best_r.wr_state == WS_UNRELIABLE);
  assign rtt_sum = {1'b0, best_r.rtt} + {1'b0, min_imp_r};
  assign gain_ok = (rtt_sum <= {1'b0, ram_rdata.rtt});
  assign sw      = best_found_r && ready &&
                   !(sel_valid_r && (sel_slot_r == best_idx_r)) &&
                   (!sel_valid_r || gain_ok);

  always_comb begin
    out_word_nxt = '0;
    if (cmd.finish) begin
      out_word_nxt.switch_found = sw;
      out_word_nxt.switch_slot  = sw ? 4'(best_idx_r) : 4'd0;
      out_word_nxt.best_valid   = best_found_r;
      out_word_nxt.best_slot    = best_found_r ? 4'(best_idx_r) : 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      sel_valid_r  <= 1'b0;
      sel_slot_r   <= '0;
      min_imp_r    <= MIN_IMP_RESET;
      cmp_v_r      <= 1'b0;
      best_found_r <= 1'b0;
      out_strobe_r <= 1'b0;
      idx_r        <= '0;
    end else begin
      valid_r      <= valid_nxt;
      sel_valid_r  <= sel_valid_nxt;
      sel_slot_r   <= sel_slot_nxt;
      if (cfg_we) begin
        min_imp_r <= cfg_wdata;
      end
      cmp_v_r      <= cmd.scan_rd;
      best_found_r <= best_found_nxt;
      out_strobe_r <= cmd.apply || cmd.finish;
      idx_r        <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r  <= idx_r;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

`default_nettype wire

/* hw/rtl/connection_pair_selector.sv */
// Top level of the connection pair selector.
//
// A command word is taken on in_word at a clock edge where start is high and
// busy is low. Write, remove and select words update the pair table or the
// selection in that edge and are never busy; their result word, all zeros, is
// shown on out_word with out_strobe high in the next cycle, so one such word
// can be taken every cycle.
// An evaluate word scans the table through the single read port of the pair
// RAM, one slot per cycle, then reads the selected entry for the RTT
// hysteresis check. busy stays high through the scan, the read of the selected
// entry and the finish step, and the result word is registered from the finish step.
// Every result word is shown for exactly one cycle; the receiver has no way
// to hold it, so it must take it in that cycle.
// cfg_wdata is written to the minimum RTT improvement register at any edge
// where cfg_we is high; write it only while no word is in flight.
// Synchronous reset clears all valid bits and the selection and loads the
// improvement register with 10 ms. Entry contents are not cleared; the data of
// an entry is only used while its valid bit, set by a write, is high.
`default_nettype none

module connection_pair_selector #(
  parameter int MAX_PAIRS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire cps_pkg::cps_in_t  in_word,
  output logic                   out_strobe,
  output cps_pkg::cps_out_t      out_word,
  input  wire logic              cfg_we,
  input  wire logic [15:0]       cfg_wdata
);
  import cps_pkg::*;

  cps_cmd_t    cmd;
  cps_status_t status;

  cps_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_word.mode),
    .status  (status),
    .busy    (busy),
    .cmd     (cmd)
  );

  cps_dp #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .status     (status),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule

`default_nettype wire
